/* rtl/core/ips_pkg.sv */
// Package for the incremental prefix search block: payload structs, opcodes,
// result codes, controller states and the controller/datapath command bundles.
// No dependencies.
`default_nettype none

package ips_pkg;

  typedef enum logic [1:0] {
    OP_LETTER = 2'd0,
    OP_LENGTH = 2'd1,
    OP_START  = 2'd2,
    OP_EXTEND = 2'd3
  } ips_op_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_NONE    = 3'd1,
    ST_EXACT   = 3'd2,
    ST_PARTIAL = 3'd3,
    ST_FULL    = 3'd4
  } ips_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_HI_RD,
    S_HI_CMP,
    S_LO_RD,
    S_LO_CMP,
    S_CHK,
    S_OUT
  } ips_state_e;

  localparam int unsigned WordCountBits = 13;

  typedef struct packed {
    ips_op_e     op;
    logic [11:0] entry_index;
    logic [3:0]  letter_position;
    logic [20:0] letter;
    logic [4:0]  word_length;
  } ips_in_t;

  typedef struct packed {
    ips_status_e status;
    logic [12:0] range_low;
    logic [12:0] range_high;
    logic [4:0]  prefix_length;
  } ips_out_t;

  // Controller to datapath
  typedef struct packed {
    logic        load_item;
    logic        exec;
    logic        rd_mid;
    logic        rd_low;
    logic        step_cmp;
    logic        hi_done;
    logic        commit;
    ips_status_e status;
    logic        load_out;
  } ips_cmd_t;

  // Datapath to controller
  typedef struct packed {
    ips_op_e op;
    logic    full;
    logic    empty;
    logic    lo_eq_end;
    logic    equal;
  } ips_stat_t;

endpackage

`default_nettype wire

/* rtl/core/incremental_prefix_search.sv */
// Top level of the incremental prefix search block: joins controller and
// datapath. Uses ips_pkg, ips_ctrl and ips_dpath.
//
//   port group   direction  transfer when
//   in_*         in         in_valid_i && in_ready_o
//   out_*        out        out_valid_o && out_ready_i
//   cfg_*        in         cfg_we_i (word count, no wait)
//
// One item at a time. Writes and start go from idle through execute and output back to idle.
// An extend with room in the prefix runs two lower-bound searches over its range, then
// the exact-match check, skipped when the range comes out empty; each binary search
// step is one registered whole-word table read followed by the compare.
// Reset clears word count and prefix length; the table needs no clearing.
// A stalled result holds in the output register; the next item is taken and
// processed, then waits for the register to free before its result loads.
`default_nettype none

module incremental_prefix_search #(
  parameter int unsigned MAX_WORDS   = 4096,
  parameter int unsigned MAX_LETTERS = 16,
  parameter int unsigned LETTER_BITS = 21
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [12:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ips_pkg::ips_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ips_pkg::ips_out_t out_data_o
);

  ips_pkg::ips_cmd_t  cmd;
  ips_pkg::ips_stat_t stat;

  ips_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ips_dpath #(
    .MAX_WORDS   (MAX_WORDS),
    .MAX_LETTERS (MAX_LETTERS),
    .LETTER_BITS (LETTER_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

/* rtl/core/ips_ctrl.sv */
// Controller of the incremental prefix search: sequences writes, the two
// lower-bound searches and the exact-match check. Uses ips_pkg.
`default_nettype none

module ips_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ips_pkg::ips_stat_t stat_i,
  output ips_pkg::ips_cmd_t  cmd_o
);

  ips_pkg::ips_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ips_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ips_pkg::ST_DONE;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ips_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ips_pkg::S_EXEC;
        end
      end
      ips_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.op == ips_pkg::OP_EXTEND && !stat_i.full) state_d = ips_pkg::S_HI_RD;
        else state_d = ips_pkg::S_OUT;
      end
      ips_pkg::S_HI_RD: begin
        if (stat_i.empty) begin
          cmd_o.hi_done = 1'b1;
          state_d = ips_pkg::S_LO_RD;
        end else begin
          cmd_o.rd_mid = 1'b1;
          state_d = ips_pkg::S_HI_CMP;
        end
      end
      ips_pkg::S_HI_CMP: begin
        cmd_o.step_cmp = 1'b1;
        state_d = ips_pkg::S_HI_RD;
      end
      ips_pkg::S_LO_RD: begin
        if (stat_i.empty) begin
          if (stat_i.lo_eq_end) begin
            cmd_o.commit = 1'b1;
            cmd_o.status = ips_pkg::ST_NONE;
            state_d = ips_pkg::S_OUT;
          end else begin
            cmd_o.rd_low = 1'b1;
            state_d = ips_pkg::S_CHK;
          end
        end else begin
          cmd_o.rd_mid = 1'b1;
          state_d = ips_pkg::S_LO_CMP;
        end
      end
      ips_pkg::S_LO_CMP: begin
        cmd_o.step_cmp = 1'b1;
        state_d = ips_pkg::S_LO_RD;
      end
      ips_pkg::S_CHK: begin
        cmd_o.commit = 1'b1;
        cmd_o.status = stat_i.equal ? ips_pkg::ST_EXACT : ips_pkg::ST_PARTIAL;
        state_d = ips_pkg::S_OUT;
      end
      ips_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = ips_pkg::S_IDLE;
        end
      end
      default: state_d = ips_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_step_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_cmp |-> !stat_i.empty) else $error("compare step on empty range");
  a_commit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !stat_i.full) else $error("commit with full prefix");
  a_item_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> state_q == ips_pkg::S_EXEC) else $error("item not executed");
`endif

endmodule

`default_nettype wire

/* rtl/core/ips_dpath.sv */
// Datapath of the incremental prefix search: word table, prefix, range stack,
// binary search registers and whole-word comparator. Uses ips_pkg.
`default_nettype none

module ips_dpath #(
  parameter int unsigned MAX_WORDS   = 4096,
  parameter int unsigned MAX_LETTERS = 16,
  parameter int unsigned LETTER_BITS = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [12:0]         cfg_wdata_i,
  input  ips_pkg::ips_in_t    in_data_i,
  output ips_pkg::ips_out_t   out_data_o,
  input  ips_pkg::ips_cmd_t   cmd_i,
  output ips_pkg::ips_stat_t  stat_o
);

  localparam int unsigned AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW  = $clog2(MAX_WORDS + 1);
  localparam int unsigned LW  = $clog2(MAX_LETTERS);
  localparam int unsigned PCW = $clog2(MAX_LETTERS + 1);
  localparam int unsigned KW  = LETTER_BITS + 1;

  ips_pkg::ips_in_t item_q;
  ips_pkg::ips_out_t out_q;
  logic [ips_pkg::WordCountBits-1:0] word_count_q;
  logic [PCW-1:0] pc_q;
  logic inc_q;
  logic [CW-1:0] s_lo_q, s_hi_q, base_lo_q, end_q, mid_q;
  logic [CW-1:0] res_lo_q, res_hi_q;
  ips_pkg::ips_status_e res_status_q;
  logic [LETTER_BITS-1:0] prefix_q [MAX_LETTERS];
  logic [CW-1:0] stk_lo_q [MAX_LETTERS];
  logic [CW-1:0] stk_hi_q [MAX_LETTERS];
  logic [LETTER_BITS-1:0] rd_let_q [MAX_LETTERS];
  logic [PCW-1:0] rd_len_q;
  logic [PCW-1:0] len_mem [MAX_WORDS];

  logic [CW-1:0] tsize, mid, base_lo, base_hi, rd_idx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [LETTER_BITS-1:0] cur_letter;
  logic entry_ok, pos_ok, full, rd_en;
  logic [PCW-1:0] klen, ncmp, wlen_sat;
  logic less, equal, diff;

  assign cur_letter = item_q.letter[LETTER_BITS-1:0];
  assign entry_ok = 32'(item_q.entry_index) < MAX_WORDS;
  assign pos_ok   = 32'(item_q.letter_position) < MAX_LETTERS;
  assign wr_addr  = AW'(item_q.entry_index);
  assign full     = 32'(pc_q) >= MAX_LETTERS;
  assign tsize    = (32'(word_count_q) > MAX_WORDS) ? CW'(MAX_WORDS) : CW'(word_count_q);
  assign mid      = s_lo_q + ((s_hi_q - s_lo_q) >> 1);
  assign base_lo  = (pc_q == '0) ? '0 : stk_lo_q[LW'(pc_q - 1'b1)];
  assign base_hi  = (pc_q == '0) ? tsize : stk_hi_q[LW'(pc_q - 1'b1)];
  assign rd_idx   = cmd_i.rd_low ? s_lo_q : mid;
  assign rd_addr  = AW'(rd_idx);
  assign rd_en    = cmd_i.rd_mid || cmd_i.rd_low;
  assign wlen_sat = (32'(item_q.word_length) > MAX_LETTERS) ? PCW'(MAX_LETTERS)
                                                            : PCW'(item_q.word_length);

  // Table lanes: one memory per letter position, read as a whole word
  for (genvar g = 0; g < MAX_LETTERS; g++) begin : g_lane
    logic [LETTER_BITS-1:0] mem [MAX_WORDS];
    always_ff @(posedge clk_i) begin
      if (cmd_i.exec && item_q.op == ips_pkg::OP_LETTER && entry_ok && pos_ok &&
          32'(item_q.letter_position) == g) begin
        mem[wr_addr] <= cur_letter;
      end
      if (rd_en) begin
        rd_let_q[g] <= mem[rd_addr];
      end
    end
  end

  // Word length memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && item_q.op == ips_pkg::OP_LENGTH && entry_ok) begin
      len_mem[wr_addr] <= wlen_sat;
    end
    if (rd_en) begin
      rd_len_q <= len_mem[rd_addr];
    end
  end

  // Compare the read word with prefix plus candidate letter
  assign klen = PCW'(pc_q + 1'b1);
  assign ncmp = (rd_len_q < klen) ? rd_len_q : klen;
  always_comb begin
    logic [KW-1:0] key;
    less = 1'b0;
    diff = 1'b0;
    for (int k = MAX_LETTERS - 1; k >= 0; k--) begin
      key = (PCW'(k) == pc_q) ? (KW'({1'b0, cur_letter}) + KW'(inc_q))
                              : KW'({1'b0, prefix_q[k]});
      if (PCW'(k) < ncmp && KW'({1'b0, rd_let_q[k]}) != key) begin
        diff = 1'b1;
        less = KW'({1'b0, rd_let_q[k]}) < key;
      end
    end
    if (!diff) less = rd_len_q < klen;
    equal = !diff && (rd_len_q == klen);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
      pc_q         <= '0;
      inc_q        <= 1'b0;
    end else begin
      if (cfg_we_i) word_count_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        inc_q <= 1'b1;
        if (item_q.op == ips_pkg::OP_START) pc_q <= '0;
      end
      if (cmd_i.hi_done) inc_q <= 1'b0;
      if (cmd_i.commit) pc_q <= klen;
    end
  end

  // Search and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.exec) begin
      s_lo_q    <= base_lo;
      s_hi_q    <= base_hi;
      base_lo_q <= base_lo;
      case (item_q.op)
        ips_pkg::OP_EXTEND: begin
          res_lo_q     <= base_lo;
          res_hi_q     <= base_hi;
          res_status_q <= ips_pkg::ST_FULL;
        end
        ips_pkg::OP_START: begin
          res_lo_q     <= '0;
          res_hi_q     <= tsize;
          res_status_q <= ips_pkg::ST_DONE;
        end
        default: begin
          res_lo_q     <= '0;
          res_hi_q     <= '0;
          res_status_q <= ips_pkg::ST_DONE;
        end
      endcase
    end
    if (cmd_i.rd_mid) mid_q <= mid;
    if (cmd_i.step_cmp) begin
      if (less) s_lo_q <= CW'(mid_q + 1'b1);
      else s_hi_q <= mid_q;
    end
    if (cmd_i.hi_done) begin
      end_q  <= s_lo_q;
      s_hi_q <= s_lo_q;
      s_lo_q <= base_lo_q;
    end
    if (cmd_i.commit) begin
      prefix_q[LW'(pc_q)] <= cur_letter;
      stk_lo_q[LW'(pc_q)] <= s_lo_q;
      stk_hi_q[LW'(pc_q)] <= end_q;
      res_lo_q     <= s_lo_q;
      res_hi_q     <= end_q;
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.load_out) begin
      out_q.status        <= res_status_q;
      out_q.range_low     <= 13'(res_lo_q);
      out_q.range_high    <= 13'(res_hi_q);
      out_q.prefix_length <= 5'(pc_q);
    end
  end

  assign out_data_o       = out_q;
  assign stat_o.op        = item_q.op;
  assign stat_o.full      = full;
  assign stat_o.empty     = s_lo_q == s_hi_q;
  assign stat_o.lo_eq_end = s_lo_q == end_q;
  assign stat_o.equal     = equal;

endmodule

`default_nettype wire

/* tb/ips_search_checker.sv */
// Checker for the incremental prefix search block: watches the config port and both
// channels, predicts each result, and compares it with what the block sends.
// Depends on ips_pkg.
`timescale 1ns / 1ps

module ips_search_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [12:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  ips_pkg::ips_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ips_pkg::ips_out_t out_data_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o
);

  localparam int unsigned Words   = 4096;
  localparam int unsigned Letters = 16;

  // Shadow copy of the block's table, prefix and range stack
  logic [20:0] tbl_letter [Words][Letters];
  logic [4:0]  tbl_len    [Words];
  logic [20:0] prefix_q   [Letters];
  logic [12:0] stack_lo   [Letters];
  logic [12:0] stack_hi   [Letters];
  logic [21:0] probe      [Letters];
  int unsigned prefix_cnt;
  logic [12:0] word_cnt;
  ips_pkg::ips_out_t expected_ranges [$];
  int unsigned mismatches;

  initial begin
    foreach (tbl_len[i]) tbl_len[i] = '0;
    foreach (tbl_letter[i, j]) tbl_letter[i][j] = '0;
    mismatches = 0;
  end

  function automatic int unsigned table_size();
    return (word_cnt > Words) ? Words : 32'(word_cnt);
  endfunction

  // Lexicographic order of table word idx against the probe key
  function automatic int word_order(int unsigned idx, int unsigned klen);
    int unsigned wlen;
    int unsigned n;
    wlen = 32'(tbl_len[idx]);
    n = (wlen < klen) ? wlen : klen;
    for (int unsigned k = 0; k < n; k++) begin
      if ({1'b0, tbl_letter[idx][k]} < probe[k]) return -1;
      if ({1'b0, tbl_letter[idx][k]} > probe[k]) return 1;
    end
    if (wlen < klen) return -1;
    if (wlen > klen) return 1;
    return 0;
  endfunction

  function automatic int unsigned first_not_less(int unsigned lo, int unsigned hi,
                                                 int unsigned klen);
    int unsigned mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (word_order(mid, klen) < 0) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one item to the shadow state and return the result it produces
  function automatic ips_pkg::ips_out_t search_step(ips_pkg::ips_in_t it);
    ips_pkg::ips_out_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned klen;
    r = '0;
    r.status = ips_pkg::ST_DONE;
    lo = 0;
    hi = 0;
    case (it.op)
      ips_pkg::OP_LETTER: tbl_letter[it.entry_index][it.letter_position] = it.letter;
      ips_pkg::OP_LENGTH: tbl_len[it.entry_index] =
                   (it.word_length > Letters) ? 5'(Letters) : it.word_length;
      ips_pkg::OP_START: begin
        prefix_cnt = 0;
        hi = table_size();
      end
      default: begin
        if (prefix_cnt == 0) begin
          hi = table_size();
        end else begin
          lo = 32'(stack_lo[prefix_cnt - 1]);
          hi = 32'(stack_hi[prefix_cnt - 1]);
        end
        if (prefix_cnt >= Letters) begin
          r.status = ips_pkg::ST_FULL;
        end else begin
          klen = prefix_cnt + 1;
          for (int unsigned k = 0; k < prefix_cnt; k++) probe[k] = {1'b0, prefix_q[k]};
          // The incremented letter carries one extra bit and never wraps
          probe[prefix_cnt] = {1'b0, it.letter} + 22'd1;
          hi = first_not_less(lo, hi, klen);
          probe[prefix_cnt] = {1'b0, it.letter};
          lo = first_not_less(lo, hi, klen);
          prefix_q[prefix_cnt] = it.letter;
          stack_lo[prefix_cnt] = 13'(lo);
          stack_hi[prefix_cnt] = 13'(hi);
          prefix_cnt = klen;
          if (lo == hi) r.status = ips_pkg::ST_NONE;
          else if (word_order(lo, klen) == 0) r.status = ips_pkg::ST_EXACT;
          else r.status = ips_pkg::ST_PARTIAL;
        end
      end
    endcase
    r.range_low = 13'(lo);
    r.range_high = 13'(hi);
    r.prefix_length = 5'(prefix_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Track config, predict on input transfer, compare on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    ips_pkg::ips_out_t want;
    ips_pkg::ips_out_t pred;
    if (!rst_ni) begin
      prefix_cnt = 0;
      word_cnt = '0;
      expected_ranges.delete();
    end else begin
      if (cfg_we_i) word_cnt = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        pred = search_step(in_data_i);
        expected_ranges = {expected_ranges, pred};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_ranges.size() == 0) begin
          report_mismatch("result with nothing expected, status", out_data_i.status, 0);
        end else begin
          want = expected_ranges.pop_front();
          if (out_data_i.status != want.status)
            report_mismatch("status", out_data_i.status, want.status);
          if (out_data_i.range_low != want.range_low)
            report_mismatch("range_low", out_data_i.range_low, want.range_low);
          if (out_data_i.range_high != want.range_high)
            report_mismatch("range_high", out_data_i.range_high, want.range_high);
          if (out_data_i.prefix_length != want.prefix_length)
            report_mismatch("prefix_length", out_data_i.prefix_length,
                            want.prefix_length);
        end
      end
    end
    pending_o <= expected_ranges.size();
    mismatch_cnt_o <= mismatches;
  end

endmodule

/* tb/incremental_prefix_search_tb.sv */
// Top of the incremental prefix search testbench: clock, reset, stimulus and verdict.
// Loads a sorted random dictionary, runs searches under random stalls on both sides.
// Depends on ips_pkg, incremental_prefix_search and ips_search_checker.
`timescale 1ns / 1ps

module incremental_prefix_search_tb;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DictMax   = 64;
  localparam logic [20:0] LetterMax = 21'h1FFFFF;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [12:0]       cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  ips_pkg::ips_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  ips_pkg::ips_out_t out_data_o;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  // Dictionary kept sorted and free of duplicates
  logic [20:0] dict_let [DictMax][16];
  int unsigned dict_len [DictMax];
  int unsigned dict_n;
  logic [20:0] cand_let [16];
  int unsigned cand_len;
  logic [20:0] alpha_base;
  bit          written [4096][16];
  bit          calm_in;
  bit          calm_out;
  int unsigned items_sent;
  int unsigned settings_seen;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  incremental_prefix_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  ips_search_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // Count cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IdleLimit);
    $display("timeout: no transfer for %0d cycles", IdleLimit);
    $display("incremental_prefix_search_tb: FAIL");
    $finish;
  end

  // Result side: random stall before each transfer, with calm stretches
  initial begin
    int unsigned gap;
    calm_out = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = calm_out ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Drive one item and hold it until the transfer
  task automatic send(ips_pkg::ips_op_e op, int unsigned entry, int unsigned pos,
                      logic [20:0] ltr, logic [4:0] wlen);
    int unsigned      gap;
    ips_pkg::ips_in_t it;
    it.op = op;
    it.entry_index = 12'(entry);
    it.letter_position = 4'(pos);
    it.letter = ltr;
    it.word_length = wlen;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 15) == 0) calm_in = !calm_in;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    items_sent++;
  endtask

  task automatic write_letter(int unsigned entry, int unsigned pos, logic [20:0] ltr);
    written[entry][pos] = 1'b1;
    send(ips_pkg::OP_LETTER, entry, pos, ltr, 5'($urandom_range(0, 31)));
  endtask

  // Longest length whose letters are all written
  function automatic int unsigned safe_len(int unsigned entry);
    int unsigned n;
    n = 0;
    while (n < 16 && written[entry][n]) n++;
    return n;
  endfunction

  // Drain, then write the word count while the block is idle
  task automatic set_word_count(logic [12:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  function automatic logic [20:0] pick_letter();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return LetterMax;
      default: return alpha_base + 21'($urandom_range(0, 3));
    endcase
  endfunction

  // Order of dictionary word i against the candidate word
  function automatic int dict_cmp(int unsigned i);
    int unsigned n;
    n = (dict_len[i] < cand_len) ? dict_len[i] : cand_len;
    for (int unsigned k = 0; k < n; k++) begin
      if (dict_let[i][k] < cand_let[k]) return -1;
      if (dict_let[i][k] > cand_let[k]) return 1;
    end
    if (dict_len[i] < cand_len) return -1;
    if (dict_len[i] > cand_len) return 1;
    return 0;
  endfunction

  // Insert the candidate in sorted position, drop duplicates
  function automatic void dict_insert();
    int unsigned pos;
    pos = 0;
    if (dict_n >= DictMax) return;
    while (pos < dict_n && dict_cmp(pos) < 0) pos++;
    if (pos < dict_n && dict_cmp(pos) == 0) return;
    for (int unsigned i = dict_n; i > pos; i--) begin
      dict_len[i] = dict_len[i - 1];
      dict_let[i] = dict_let[i - 1];
    end
    dict_len[pos] = cand_len;
    dict_let[pos] = cand_let;
    dict_n++;
  endfunction

  task automatic build_dictionary();
    int unsigned target;
    alpha_base = 21'($urandom_range(1, 21'h1FFFF0));
    dict_n = 0;
    foreach (cand_let[k]) cand_let[k] = alpha_base + 21'($urandom_range(0, 3));
    cand_len = 16;
    dict_insert();
    cand_len = 1;
    cand_let[0] = LetterMax;
    dict_insert();
    cand_let[0] = '0;
    dict_insert();
    target = $urandom_range(8, DictMax);
    for (int unsigned t = 0; t < 4 * DictMax && dict_n < target; t++) begin
      cand_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16)
                                             : $urandom_range(1, 5);
      for (int unsigned k = 0; k < 16; k++) cand_let[k] = pick_letter();
      dict_insert();
    end
    for (int unsigned i = 0; i < dict_n; i++) begin
      for (int unsigned k = 0; k < dict_len[i]; k++) write_letter(i, k, dict_let[i][k]);
      send(ips_pkg::OP_LENGTH, i, $urandom_range(0, 15), '0, 5'(dict_len[i]));
    end
  endtask

  // Mostly follow a dictionary word, sometimes stray off it
  task automatic run_search(bit with_start);
    int unsigned t;
    int unsigned depth;
    logic [20:0] ltr;
    if (with_start) send(ips_pkg::OP_START, $urandom_range(0, 4095), $urandom_range(0, 15),
                         21'($urandom_range(0, LetterMax)), 5'($urandom_range(0, 31)));
    t = $urandom_range(0, dict_n - 1);
    depth = $urandom_range(1, 18);
    for (int unsigned k = 0; k < depth; k++) begin
      if (k < dict_len[t] && $urandom_range(0, 7) != 0) ltr = dict_let[t][k];
      else if ($urandom_range(0, 1) == 0) ltr = alpha_base + 21'($urandom_range(0, 4));
      else ltr = 21'($urandom_range(0, LetterMax));
      send(ips_pkg::OP_EXTEND, $urandom_range(0, 4095), $urandom_range(0, 15), ltr,
           5'($urandom_range(0, 31)));
    end
  endtask

  // One random step: searches, table rewrites or bare starts
  task automatic random_step();
    int unsigned entry;
    int unsigned wlen;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: run_search(1'b1);
      6: run_search(1'b0);
      7: write_letter($urandom_range(0, 4095), $urandom_range(0, 15),
                      ($urandom_range(0, 1) == 0) ? pick_letter()
                                                  : 21'($urandom_range(0, LetterMax)));
      8: begin
        entry = $urandom_range(0, 4095);
        // Never let a searchable entry claim letters that were never written
        if (entry < dict_n) wlen = $urandom_range(0, safe_len(entry));
        else wlen = $urandom_range(0, 31);
        send(ips_pkg::OP_LENGTH, entry, $urandom_range(0, 15),
             21'($urandom_range(0, LetterMax)), 5'(wlen));
      end
      default: send(ips_pkg::OP_START, $urandom_range(0, 4095), $urandom_range(0, 15),
                    21'($urandom_range(0, LetterMax)), 5'($urandom_range(0, 31)));
    endcase
  endtask

  initial begin
    calm_in = 1'b0;
    items_sent = 0;
    settings_seen = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: extremes of the letter and out-of-table writes
    send(ips_pkg::OP_START, 0, 0, '0, '0);
    send(ips_pkg::OP_EXTEND, 0, 0, '0, '0);
    send(ips_pkg::OP_EXTEND, 4095, 15, LetterMax, 5'd31);
    write_letter(4095, 15, LetterMax);
    send(ips_pkg::OP_LENGTH, 4095, 15, LetterMax, 5'd31);
    send(ips_pkg::OP_LENGTH, 4094, 0, '0, 5'd17);

    build_dictionary();
    set_word_count(13'(dict_n));

    // Walk the sixteen-letter word to exact, then one more extend hits a full prefix
    for (int unsigned i = 0; i < dict_n; i++) begin
      if (dict_len[i] == 16) begin
        send(ips_pkg::OP_START, 0, 0, '0, '0);
        for (int unsigned k = 0; k < 16; k++)
          send(ips_pkg::OP_EXTEND, 0, 0, dict_let[i][k], '0);
        send(ips_pkg::OP_EXTEND, 0, 0, pick_letter(), '0);
        break;
      end
    end

    // Random part over several word counts
    while (items_sent < 900) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: set_word_count(13'(dict_n));
          1: set_word_count('0);
          2: set_word_count(13'd1);
          default: set_word_count(13'($urandom_range(0, dict_n)));
        endcase
      end
      random_step();
    end

    // Saturated word counts: starts only, the table past the dictionary stays unread
    set_word_count(13'd4096);
    repeat (25) send(ips_pkg::OP_START, $urandom_range(0, 4095), $urandom_range(0, 15),
                     21'($urandom_range(0, LetterMax)), 5'($urandom_range(0, 31)));
    set_word_count(13'h1FFF);
    repeat (25) send(ips_pkg::OP_START, $urandom_range(0, 4095), $urandom_range(0, 15),
                     21'($urandom_range(0, LetterMax)), 5'($urandom_range(0, 31)));

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (60) @(posedge clk_i);

    $display("covered %0d transfers, %0d word-count settings, dictionary of %0d words,",
             items_sent, settings_seen, dict_n);
    $display("then starts under word counts of 4096 and above");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("incremental_prefix_search_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_cnt);
      $display("incremental_prefix_search_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ips_pkg.sv
rtl/core/ips_ctrl.sv
rtl/core/ips_dpath.sv
rtl/core/incremental_prefix_search.sv
tb/ips_search_checker.sv
tb/incremental_prefix_search_tb.sv
